FILE: hdl/msb_first_bit_packer_macros.svh
// Assertion macros used by the checker of the bit packer.
`ifndef MSB_FIRST_BIT_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_MACROS_SVH

// Clocked property, switched off while reset is held.
`define MFBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define MFBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/mfbp_pkg.sv
// Package of shared types and constants for the bit packer.
`timescale 1ns / 1ps

package mfbp_pkg;

    localparam int C_MAX_PUT_BITS = 32;
    localparam int C_BYTE_BITS    = 8;
    // Width of a per-item byte count, covering every allowed put size
    localparam int C_NB_W         = 3;

    // Item operations
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_ALIGN = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [C_NB_W-1:0] nbytes;
    } t_dp_stat;

endpackage

FILE: hdl/mfbp_datapath.sv
// Packing datapath: merges the partial byte with new bits and shifts out bytes.
`timescale 1ns / 1ps

module mfbp_datapath import mfbp_pkg::*; #(
    parameter int MAX_PUT_BITS = C_MAX_PUT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_operation,
    input  logic [5:0]  i_bit_count,
    input  logic [31:0] i_bits_value,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_total_bits,
    output logic [2:0]  o_pad_bits
);

    localparam int         W       = MAX_PUT_BITS + C_BYTE_BITS;
    localparam logic [5:0] MAX_CNT = 6'(MAX_PUT_BITS);

    // Partial byte kept left aligned, unused low bits zero
    logic [7:0]              r_pl;
    logic [31:0]             r_total;
    logic [W-1:0]            r_word;
    logic [2:0]              r_pad;

    logic [7:0]              n_pl;
    logic [31:0]             n_total;
    logic [W-1:0]            n_word;
    logic [2:0]              n_pad;

    logic [2:0]              fill;
    logic [5:0]              put_cnt;
    logic [5:0]              cnt;
    logic [31:0]             value_m;
    logic [MAX_PUT_BITS-1:0] value_l;
    logic [W-1:0]            word_l;
    logic [W-1:0]            word_sh;
    logic [5:0]              bit_sum;
    logic [C_NB_W-1:0]       nb;

    // Merge the held bits with the new code word, first bit at the top
    always_comb begin
        fill    = r_total[2:0];
        put_cnt = (i_bit_count > MAX_CNT) ? MAX_CNT : i_bit_count;
        if (i_operation == OP_ALIGN) begin
            cnt     = (fill == 3'd0) ? 6'd0 : 6'(4'd8 - {1'b0, fill});
            value_m = '0;
            n_pad   = cnt[2:0];
        end else begin
            cnt     = put_cnt;
            value_m = i_bits_value & ~({32{1'b1}} << put_cnt);
            n_pad   = 3'd0;
        end
        value_l = value_m[MAX_PUT_BITS-1:0] << (MAX_CNT - cnt);
        word_l  = {r_pl, {MAX_PUT_BITS{1'b0}}} | ({value_l, 8'b0} >> fill);
        bit_sum = {3'b000, fill} + cnt;
        nb      = C_NB_W'(bit_sum >> 3);
        word_sh = word_l << {nb, 3'b000};
        n_pl    = word_sh[W-1 -: 8];
        n_total = r_total + 32'(cnt);
        n_word  = (nb == '0) ? '0 : word_l;
    end

    // Hold the stream state across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pl    <= '0;
            r_total <= '0;
        end else if (i_cmd.load) begin
            r_pl    <= n_pl;
            r_total <= n_total;
        end
    end

    // Load the packed word, then advance one byte per sent beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= n_word;
            r_pad  <= n_pad;
        end else if (i_cmd.shift) begin
            r_word <= r_word << C_BYTE_BITS;
        end
    end

    assign o_stat.nbytes = nb;
    assign o_out_byte    = r_word[W-1 -: 8];
    assign o_total_bits  = r_total;
    assign o_pad_bits    = r_pad;

endmodule

FILE: hdl/mfbp_ctrl.sv
// Controller: takes one item, then sends its result beats in order.
`timescale 1ns / 1ps

module mfbp_ctrl import mfbp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output logic     o_byte_valid,
    output logic     o_last,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state            r_state;
    logic [C_NB_W-1:0] r_left;
    logic              r_byte_valid;

    // State, beats left and byte flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_left       <= '0;
            r_byte_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state      <= ST_SEND;
                        r_byte_valid <= (i_stat.nbytes != '0);
                        r_left       <= (i_stat.nbytes == '0) ? C_NB_W'(1) : i_stat.nbytes;
                    end
                end
                ST_SEND: begin
                    if (i_out_ready) begin
                        if (r_left == C_NB_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                        r_left <= r_left - C_NB_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive handshakes and datapath commands
    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        o_out_valid  = (r_state == ST_SEND);
        o_byte_valid = r_byte_valid;
        o_last       = (r_left == C_NB_W'(1));
        o_cmd.load   = o_in_ready && i_in_valid;
        o_cmd.shift  = o_out_valid && i_out_ready;
    end

endmodule

FILE: hdl/msb_first_bit_packer.sv
// MSB-first bit packer: packs code words into bytes, one item at a time.
// Each item (append up to 32 bits, or pad with zeros to the byte boundary)
// is accepted whole, and in that cycle the held partial byte and the new bits
// are merged into one packing word; the completed bytes then leave through
// the output register at one beat per cycle while i_ready is high, first
// written bit in bit 7. An item that completes no byte gives a single beat
// with byte_valid low. An item thus gives 1 to 4 result beats, and the
// controller holds off the next item until the last beat of the current one
// has been taken. Every beat carries the running bit total after the item
// and the pad count of an align.
`timescale 1ns / 1ps

module msb_first_bit_packer import mfbp_pkg::*; #(
    parameter int MAX_PUT_BITS = C_MAX_PUT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [5:0]  i_bit_count,
    input  logic [31:0] i_bits_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_byte_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic [31:0] o_total_bits,
    output logic [2:0]  o_pad_bits
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence items and result beats
    mfbp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .o_in_ready   (o_ready),
        .o_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat)
    );

    // Merge bits and shift out bytes
    mfbp_datapath #(
        .MAX_PUT_BITS (MAX_PUT_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_operation  (i_operation),
        .i_bit_count  (i_bit_count),
        .i_bits_value (i_bits_value),
        .o_out_byte   (o_out_byte),
        .o_total_bits (o_total_bits),
        .o_pad_bits   (o_pad_bits)
    );

endmodule

FILE: hdl/mfbp_checker.sv
// Port-level checker for the bit packer, bound to the top level.
`timescale 1ns / 1ps
`include "msb_first_bit_packer_macros.svh"

module mfbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_byte_valid,
    input logic [7:0]  o_out_byte,
    input logic        o_last,
    input logic [2:0]  o_pad_bits
);

    // A stalled result beat stays offered
    `MFBP_ASSERT(a_out_hold, (o_valid && !i_ready) |=> o_valid, "result beat dropped while stalled")

    // One item at a time: no intake while beats are pending
    `MFBP_ASSERT(a_no_overlap, !(o_ready && o_valid), "item taken while results pending")

    // An accepted item always gives a beat next cycle
    `MFBP_ASSERT(a_item_result, (i_valid && o_ready) |=> o_valid, "item gave no result")

    // An empty beat carries a zero byte and closes its item
    `MFBP_ASSERT(a_empty_beat, o_valid && !o_byte_valid |-> !(|o_out_byte) && o_last, "empty beat")

    // Padding completes exactly one byte
    `MFBP_ASSERT(a_pad_one_byte, o_valid && |o_pad_bits |-> o_byte_valid && o_last, "bad pad beat")

endmodule

bind msb_first_bit_packer mfbp_checker u_mfbp_checker (.*);
